// File: src/fpa_pkg.sv
// shared types, command codes and constants for the fixed-point alu
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MIN = 3'd4,
        CMD_MAX = 3'd5,
        CMD_INC = 3'd6,
        CMD_DEC = 3'd7
    } fpa_cmd_e;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     divide_by_zero;
    } fpa_rsp_t;

    // side information that rides along with the divider stages
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [DATA_W-1:0] alt;
        logic              a_less;
        logic              a_equal;
    } fpa_meta_t;

endpackage

// File: src/fpa_front.sv
// input register, multiplier, simple ops and divider operand prep
module fpa_front #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  fpa_pkg::fpa_req_t                      request,
    output logic                                   valid,
    output fpa_pkg::fpa_meta_t                     meta,
    output logic [fpa_pkg::DATA_W+FRACTION_BITS-1:0] dvd,
    output logic [fpa_pkg::DATA_W-1:0]             dsr
);
    import fpa_pkg::*;

    localparam int DVD_W = DATA_W + FRACTION_BITS;

    // stage a: input capture
    logic     a_valid_reg;
    fpa_req_t a_req_reg;

    // stage b: products and simple results
    logic                     b_valid_reg;
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       prod_next;
    logic [DATA_W-1:0]        simple_reg;
    logic [DATA_W-1:0]        simple_next;
    logic                     is_mul_reg;
    logic                     is_div_reg;
    logic                     neg_reg;
    logic                     dz_reg;
    logic                     less_reg;
    logic                     equal_reg;
    logic [DATA_W-1:0]        absa_reg;
    logic [DATA_W-1:0]        absb_reg;

    // stage c: output of the front end
    logic                     c_valid_reg;
    fpa_meta_t                c_meta_reg;
    logic [DVD_W-1:0]         c_dvd_reg;
    logic [DATA_W-1:0]        c_dsr_reg;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic                     a_gt_b;
    fpa_cmd_e                 cmd;

    assign op_a      = a_req_reg.operand_a;
    assign op_b      = a_req_reg.operand_b;
    assign cmd       = fpa_cmd_e'(a_req_reg.command);
    assign a_gt_b    = op_a > op_b;
    assign prod_next = 64'(op_a) * 64'(op_b);

    always_comb
    begin
        case (cmd)
            CMD_ADD: simple_next = DATA_W'(op_a + op_b);
            CMD_SUB: simple_next = DATA_W'(op_a - op_b);
            CMD_MIN: simple_next = a_gt_b ? op_b : op_a;
            CMD_MAX: simple_next = a_gt_b ? op_a : op_b;
            CMD_INC: simple_next = DATA_W'(op_a + 1);
            CMD_DEC: simple_next = DATA_W'(op_a - 1);
            default: simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_req_reg  <= request;
        prod_reg   <= prod_next;
        simple_reg <= simple_next;
        is_mul_reg <= (cmd == CMD_MUL);
        is_div_reg <= (cmd == CMD_DIV);
        neg_reg    <= op_a[DATA_W-1] ^ op_b[DATA_W-1];
        dz_reg     <= (cmd == CMD_DIV) && (op_b == '0);
        less_reg   <= op_a < op_b;
        equal_reg  <= op_a == op_b;
        absa_reg   <= op_a[DATA_W-1] ? DATA_W'(-op_a) : op_a;
        absb_reg   <= op_b[DATA_W-1] ? DATA_W'(-op_b) : op_b;

        c_meta_reg.is_div  <= is_div_reg;
        c_meta_reg.neg     <= neg_reg;
        c_meta_reg.dz      <= dz_reg;
        c_meta_reg.alt     <= is_mul_reg ? prod_reg[FRACTION_BITS +: DATA_W] : simple_reg;
        c_meta_reg.a_less  <= less_reg;
        c_meta_reg.a_equal <= equal_reg;
        c_dvd_reg          <= {absa_reg, {FRACTION_BITS{1'b0}}};
        c_dsr_reg          <= absb_reg;
    end

    assign valid = c_valid_reg;
    assign meta  = c_meta_reg;
    assign dvd   = c_dvd_reg;
    assign dsr   = c_dsr_reg;

endmodule

// File: src/fpa_div_stage.sv
// one restoring divide step: one quotient bit per register stage
module fpa_div_stage #(
    parameter int DVD_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    input  fpa_pkg::fpa_meta_t         meta_in,
    input  logic [fpa_pkg::DATA_W-1:0] rem_in,
    input  logic [DVD_W-1:0]           dvd_in,
    input  logic [fpa_pkg::DATA_W-1:0] dsr_in,
    output logic                       valid_out,
    output fpa_pkg::fpa_meta_t         meta_out,
    output logic [fpa_pkg::DATA_W-1:0] rem_out,
    output logic [DVD_W-1:0]           dvd_out,
    output logic [fpa_pkg::DATA_W-1:0] dsr_out
);
    import fpa_pkg::*;

    logic              valid_reg;
    fpa_meta_t         meta_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [DATA_W-1:0] dsr_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign shifted  = {rem_in, dvd_in[DVD_W-1]};
    assign diff     = shifted - {1'b0, dsr_in};
    assign fits     = shifted >= {1'b0, dsr_in};
    // remainder stays below the divisor, so the top bit drops cleanly
    assign rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    assign dvd_next = {dvd_in[DVD_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_in;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_in;
    end

    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign rem_out   = rem_reg;
    assign dvd_out   = dvd_reg;
    assign dsr_out   = dsr_reg;

endmodule

// File: src/fpa_divider.sv
// pipelined unsigned divider: chain of one-bit restoring stages
module fpa_divider #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     valid_in,
    input  fpa_pkg::fpa_meta_t                       meta_in,
    input  logic [fpa_pkg::DATA_W+FRACTION_BITS-1:0] dvd_in,
    input  logic [fpa_pkg::DATA_W-1:0]               dsr_in,
    output logic                                     valid_out,
    output fpa_pkg::fpa_meta_t                       meta_out,
    output logic [fpa_pkg::DATA_W-1:0]               quot_out
);
    import fpa_pkg::*;

    localparam int DVD_W = DATA_W + FRACTION_BITS;

    logic              valid_w [0:DVD_W];
    fpa_meta_t         meta_w  [0:DVD_W];
    logic [DATA_W-1:0] rem_w   [0:DVD_W];
    logic [DVD_W-1:0]  dvd_w   [0:DVD_W];
    logic [DATA_W-1:0] dsr_w   [0:DVD_W];

    assign valid_w[0] = valid_in;
    assign meta_w[0]  = meta_in;
    assign rem_w[0]   = '0;
    assign dvd_w[0]   = dvd_in;
    assign dsr_w[0]   = dsr_in;

    for (genvar i = 0; i < DVD_W; i++)
    begin : g_stage
        fpa_div_stage #(
            .DVD_W (DVD_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_w[i]),
            .meta_in   (meta_w[i]),
            .rem_in    (rem_w[i]),
            .dvd_in    (dvd_w[i]),
            .dsr_in    (dsr_w[i]),
            .valid_out (valid_w[i+1]),
            .meta_out  (meta_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .dvd_out   (dvd_w[i+1]),
            .dsr_out   (dsr_w[i+1])
        );
    end

    // after all steps the dividend word holds the quotient
    assign valid_out = valid_w[DVD_W];
    assign meta_out  = meta_w[DVD_W];
    assign quot_out  = dvd_w[DVD_W][DATA_W-1:0];

endmodule

// File: src/fixed_point_q24_8_alu_top.sv
// top level of the pipelined signed fixed-point alu
//
// usage:
//   a command and two raw fixed-point operands are presented on request
//   together with start; a transfer happens on any clock edge where start
//   is high and busy is low. busy is always low: the pipeline takes a new
//   transfer every cycle with no gaps.
//   every transfer yields exactly one response, shown on response for one
//   cycle with done high, in the same order the requests came in.
// pipeline:
//   done rises once the request has passed every pipeline stage, the same
//   for every command; done and response come from the same output
//   register.
//   the divider sets the depth: it resolves one quotient bit per stage,
//   32 + FRACTION_BITS stages; the other stages are input capture,
//   multiply, alignment and the output register.
// throughput: one item per cycle.
// reset: clears all valid bits, so no response comes out of a stale stage.
// the receiver cannot stall; responses must be taken as they appear.
module fixed_point_q24_8_alu_top #(
    parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::fpa_req_t request,
    output logic              done,
    output fpa_pkg::fpa_rsp_t response
);
    import fpa_pkg::*;

    localparam int DVD_W   = DATA_W + FRACTION_BITS;
    localparam int LATENCY = DVD_W + 4;

    // front end to divider
    logic              f_valid;
    fpa_meta_t         f_meta;
    logic [DVD_W-1:0]  f_dvd;
    logic [DATA_W-1:0] f_dsr;

    // divider to output stage
    logic              d_valid;
    fpa_meta_t         d_meta;
    logic [DATA_W-1:0] d_quot;

    logic              done_reg;
    fpa_rsp_t          rsp_reg;
    fpa_rsp_t          rsp_next;
    logic [DATA_W-1:0] quot_signed;

    // no backpressure anywhere in the pipe
    assign busy = 1'b0;

    fpa_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start && !busy),
        .request (request),
        .valid   (f_valid),
        .meta    (f_meta),
        .dvd     (f_dvd),
        .dsr     (f_dsr)
    );

    fpa_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (f_valid),
        .meta_in   (f_meta),
        .dvd_in    (f_dvd),
        .dsr_in    (f_dsr),
        .valid_out (d_valid),
        .meta_out  (d_meta),
        .quot_out  (d_quot)
    );

    // restore the sign of the quotient; only the low word is kept
    assign quot_signed = d_meta.neg ? DATA_W'(-d_quot) : d_quot;

    always_comb
    begin
        rsp_next.a_less         = d_meta.a_less;
        rsp_next.a_equal        = d_meta.a_equal;
        rsp_next.divide_by_zero = d_meta.dz;
        if (d_meta.dz)
            rsp_next.result_value = '0;
        else if (d_meta.is_div)
            rsp_next.result_value = quot_signed;
        else
            rsp_next.result_value = d_meta.alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

    // a response only follows a request transfer a fixed latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("response without matching request");

    // divide by zero always reports a zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && response.divide_by_zero |-> response.result_value == '0)
        else $error("divide by zero with nonzero result");

    // less and equal cannot both hold
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(response.a_less && response.a_equal))
        else $error("less and equal flags both set");

endmodule
